// File: hdl/gpmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpmm_pkg: shared types and constants for the GF(2) polynomial multiplier
// Request and response payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package gpmm_pkg;

   localparam int OPERAND_W  = 16;
   localparam int RAW_W      = 31;
   localparam int REDUCED_W  = 16;
   localparam int MOD_LOW_W  = 16;
   localparam int MOD_DEG_W  = 5;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Number of coefficient bits used from each operand. The payload and
   // response field widths above are sized for this value.
   localparam int COEFF_BITS = 16;

   // Number of product bit positions that one reduction stage retires.
   localparam int RED_STEPS = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_LOW    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_DEGREE = 1'd1;

   localparam logic [MOD_LOW_W-1:0] MOD_LOW_RESET = 16'd27;
   localparam logic [MOD_DEG_W-1:0] MOD_DEG_RESET = 5'd8;

   typedef struct packed {
      logic [OPERAND_W-1:0] operand_a;
      logic [OPERAND_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]     raw_product;
      logic [REDUCED_W-1:0] reduced_product;
   } rsp_type;

endpackage

// File: hdl/gpmm_red_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpmm_red_stage: one pipeline stage of the modular reduction
// Clears up to STEPS product bits, top down, by XORing in the modulus
// aligned to each cleared position. Holds its own valid bit and handshake.
// ----------------------------------------------------------------------------
module gpmm_red_stage
   import gpmm_pkg::*;
#(
   parameter int PROD_WIDTH = 31,
   parameter int TOP_BIT    = 30,
   parameter int STEPS      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [PROD_WIDTH-1:0] in_prod,
   input  logic [PROD_WIDTH-1:0] in_raw,
   input  logic [PROD_WIDTH-1:0] m_top,
   input  logic [PROD_WIDTH-1:0] step_en,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [PROD_WIDTH-1:0] out_prod,
   output logic [PROD_WIDTH-1:0] out_raw
);

   logic                  valid_ff;
   logic [PROD_WIDTH-1:0] prod_ff;
   logic [PROD_WIDTH-1:0] raw_ff;
   logic [PROD_WIDTH-1:0] prod_in;

   assign in_ready = !valid_ff || out_ready;

   // The modulus is kept aligned with its leading term at the top bit, so
   // each position needs only a fixed right shift of it.
   always_comb begin
      prod_in = in_prod;
      for (int j = 0; j < STEPS; j++) begin
         prod_in = prod_in ^ ({PROD_WIDTH{step_en[TOP_BIT-j] & prod_in[TOP_BIT-j]}}
                              & (m_top >> (PROD_WIDTH - 1 - TOP_BIT + j)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
         raw_ff  <= in_raw;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_raw   = raw_ff;

endmodule

// File: hdl/gf2_poly_mul_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_mul_mod_unit: carry-less multiply and reduce over GF(2)
// Forms the carry-less product of two binary polynomials and its remainder
// modulo x^degree + low bits, returning both for each request.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle unless stalled and returns a response
// for each. R = ceil((2*COEFF_BITS-1)/8) is the number of reduction stages.
// One stage registers the operands, one forms the carry-less product, and
// each reduction stage retires up to eight product bit positions. Stalls hold the
// whole pipeline in place; empty stages still fill while the output waits.
// Write the modulus registers only while no request is in flight.
module gf2_poly_mul_mod_unit
   import gpmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int ProdW   = 2 * COEFF_BITS - 1;
   localparam int DegW    = $clog2(COEFF_BITS + 1);
   localparam int ShiftW  = $clog2(ProdW);
   localparam int NumRed  = (ProdW + RED_STEPS - 1) / RED_STEPS;

   // Configuration registers and values derived from them.
   logic [MOD_LOW_W-1:0]  mod_low_ff;
   logic [MOD_DEG_W-1:0]  mod_deg_ff;
   logic [DegW-1:0]       deg_eff;
   logic [COEFF_BITS-1:0] deg_mask_in;
   logic [COEFF_BITS-1:0] deg_mask_ff;
   logic [ProdW-1:0]      m_full;
   logic [ProdW-1:0]      m_top_in;
   logic [ProdW-1:0]      m_top_ff;
   logic [ProdW-1:0]      step_en_in;
   logic [ProdW-1:0]      step_en_ff;

   // Operand and product stages.
   logic                  s1_valid_ff;
   logic                  s1_ready;
   logic [COEFF_BITS-1:0] s1_a_ff;
   logic [COEFF_BITS-1:0] s1_b_ff;
   logic                  s2_valid_ff;
   logic                  s2_ready;
   logic [ProdW-1:0]      s2_prod_ff;
   logic [ProdW-1:0]      s2_prod_in;

   // Reduction chain; entry 0 is fed by the product stage.
   logic                  chain_valid [NumRed+1];
   logic                  chain_ready [NumRed+1];
   logic [ProdW-1:0]      chain_prod  [NumRed+1];
   logic [ProdW-1:0]      chain_raw   [NumRed+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_low_ff <= MOD_LOW_RESET;
         mod_deg_ff <= MOD_DEG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODULUS_LOW:    mod_low_ff <= csr_wr_data[MOD_LOW_W-1:0];
            CSR_MODULUS_DEGREE: mod_deg_ff <= csr_wr_data[MOD_DEG_W-1:0];
            default:            mod_low_ff <= mod_low_ff;
         endcase
      end
   end

   // The degree saturates at COEFF_BITS so the remainder fits its field.
   always_comb begin
      if (int'(mod_deg_ff) > COEFF_BITS) begin
         deg_eff = DegW'(COEFF_BITS);
      end else begin
         deg_eff = DegW'(mod_deg_ff);
      end
      for (int i = 0; i < COEFF_BITS; i++) begin
         deg_mask_in[i] = (i < int'(deg_eff));
      end
      for (int i = 0; i < ProdW; i++) begin
         step_en_in[i] = (i >= int'(deg_eff));
      end
      m_full   = (ProdW'(1) << deg_eff)
                 | ProdW'(COEFF_BITS'(mod_low_ff) & deg_mask_in);
      m_top_in = m_full << (ShiftW'(ProdW - 1) - ShiftW'(deg_eff));
   end

   always_ff @(posedge clock) begin
      deg_mask_ff <= deg_mask_in;
      m_top_ff    <= m_top_in;
      step_en_ff  <= step_en_in;
   end

   // Operand register.
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_a_ff <= COEFF_BITS'(req_payload.operand_a);
         s1_b_ff <= COEFF_BITS'(req_payload.operand_b);
      end
   end

   // Carry-less product: XOR of shifted copies of a, one per set bit of b.
   always_comb begin
      s2_prod_in = '0;
      for (int i = 0; i < COEFF_BITS; i++) begin
         s2_prod_in = s2_prod_in
                      ^ ({ProdW{s1_b_ff[i]}} & (ProdW'(s1_a_ff) << i));
      end
   end

   assign s2_ready = !s2_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_prod_ff <= s2_prod_in;
      end
   end

   assign chain_valid[0] = s2_valid_ff;
   assign chain_prod[0]  = s2_prod_ff;
   assign chain_raw[0]   = s2_prod_ff;

   for (genvar k = 0; k < NumRed; k++) begin : g_red
      localparam int TopBit = ProdW - 1 - RED_STEPS * k;
      localparam int Steps  = (TopBit + 1 < RED_STEPS) ? TopBit + 1 : RED_STEPS;

      gpmm_red_stage #(
         .PROD_WIDTH (ProdW),
         .TOP_BIT    (TopBit),
         .STEPS      (Steps)
      ) u_red_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_prod   (chain_prod[k]),
         .in_raw    (chain_raw[k]),
         .m_top     (m_top_ff),
         .step_en   (step_en_ff),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_prod  (chain_prod[k+1]),
         .out_raw   (chain_raw[k+1])
      );
   end

   assign chain_ready[NumRed] = !rsp_stall;

   assign rsp_valid                   = chain_valid[NumRed];
   assign rsp_payload.raw_product     = RAW_W'(chain_raw[NumRed]);
   assign rsp_payload.reduced_product =
      REDUCED_W'(chain_prod[NumRed][COEFF_BITS-1:0] & deg_mask_ff);

   // With the output free, every stage can advance, so no request waits.
   a_no_stall_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the output was free");

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted request did not enter the operand stage");

   a_remainder_degree : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((chain_prod[NumRed][COEFF_BITS-1:0] & ~deg_mask_ff)
                     & chain_prod[NumRed][COEFF_BITS-1:0] & ~deg_mask_ff) == '0)
      else $error("reduction left bits at or above the modulus degree");

endmodule
